>>> hdl/cprm_pkg.sv
// Shared types and constants for the coprocessor register move unit.
package cprm_pkg;

   localparam int unsigned REG_COUNT = 32;
   localparam int unsigned ADDR_W    = 5;
   localparam int unsigned DATA_W    = 64;
   localparam int unsigned HALF_W    = 32;

   // Instruction kinds carried on the request tuser.
   typedef enum logic [2:0] {
      KIND_TICK     = 3'd0,
      KIND_MF       = 3'd1,
      KIND_DMF      = 3'd2,
      KIND_MT       = 3'd3,
      KIND_DMT      = 3'd4,
      KIND_UNUSABLE = 3'd5,
      KIND_RESERVED = 3'd6,
      KIND_NOP      = 3'd7
   } kind_type;

   // Exception codes reported with each result item.
   typedef enum logic [1:0] {
      EXC_NONE     = 2'd0,
      EXC_UNUSABLE = 2'd1,
      EXC_RESERVED = 2'd2
   } exc_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_USABLE     = 2'd0;
   localparam logic [1:0] CSR_MODE_64    = 2'd1;
   localparam logic [1:0] CSR_RESERVED64 = 2'd2;

   // Write request into the pending slot.
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } wq_req_type;

   // Write of the delayed slot into the register file.
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } commit_type;

endpackage

>>> hdl/cprm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cprm_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read returns the old contents when the same entry is written.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/cprm_wq.sv
// Two-slot write queue: pending slot, delayed slot and commit to the file.
module cprm_wq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   tick,
   input  cprm_pkg::wq_req_type   req,
   output cprm_pkg::commit_type   commit
);
   import cprm_pkg::*;

   logic              pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [DATA_W-1:0] pend_data_ff, pend_data_in;
   logic              dly_valid_ff, dly_valid_in;
   logic [ADDR_W-1:0] dly_addr_ff, dly_addr_in;
   logic [DATA_W-1:0] dly_data_ff, dly_data_in;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      pend_data_in  = pend_data_ff;
      dly_valid_in  = dly_valid_ff;
      dly_addr_in   = dly_addr_ff;
      dly_data_in   = dly_data_ff;
      if (advance && tick) begin
         // shift pending into delayed, empty pending
         dly_valid_in  = pend_valid_ff;
         dly_addr_in   = pend_addr_ff;
         dly_data_in   = pend_data_ff;
         pend_valid_in = 1'b0;
      end else if (advance && req.valid) begin
         pend_valid_in = 1'b1;
         pend_addr_in  = req.addr;
         pend_data_in  = req.data;
         // a new write to the delayed index cancels the delayed write
         if (dly_valid_ff && (dly_addr_ff == req.addr)) begin
            dly_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         dly_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         dly_valid_ff  <= dly_valid_in;
      end
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
      dly_addr_ff  <= dly_addr_in;
      dly_data_ff  <= dly_data_in;
   end

   assign commit.we   = advance & tick & dly_valid_ff;
   assign commit.addr = dly_addr_ff;
   assign commit.data = dly_data_ff;

endmodule

>>> hdl/coprocessor_register_move_unit.sv
// Top level of the coprocessor register move unit: pipeline, file and result register.
//
// Usage:
//   The req channel takes one instruction item per cycle while req_tready is high:
//   tuser is the kind (tick, MF, DMF, MT, DMT, unusable op, reserved op, no-op),
//   tdata carries the coprocessor register, the general register and its value.
//   Every item yields exactly one rsp item with the exception code, the
//   general register load request and the moved value.
//   The csr channel writes the three status bits; it is always ready. The user must
//   write it only while the unit is idle; the unit itself does not enforce this.
//   A result passes through the execute stage and then the result register, which
//   drives rsp_tvalid; the accepting edge loads the execute stage and starts the
//   register file read. Throughput: one item per cycle while rsp_tready stays high,
//   set by the single read port of the register file; a commit on a tick is
//   forwarded to a read issued in the same cycle.
//   When rsp_tready is low the result register holds, the execute stage
//   holds behind it, and req_tready drops once both are full.
//   Reset clears the status bits, the write slots and the per-entry valid
//   bits, so every coprocessor register reads zero; no clearing pass runs.
module coprocessor_register_move_unit #(
   parameter int unsigned COPROCESSOR_NUMBER = 1
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // dest_reg[4:0], target_reg[9:5], gpr_value[73:10]
   input  logic [2:0]  req_tuser,  // kind[2:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // gpr_index[4:0], gpr_data[68:5]
   output logic [2:0]  rsp_tuser,  // exception[1:0], gpr_write_valid[2]
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic        csr_data
);
   import cprm_pkg::*;

   // status bits
   logic usable_ff, mode_64_ff, reserved_64_ff;

   // execute stage
   logic              s1_valid_ff, s1_valid_in;
   kind_type          s1_kind_ff;
   logic [ADDR_W-1:0] s1_dest_ff;
   logic [ADDR_W-1:0] s1_target_ff;
   logic [DATA_W-1:0] s1_gpr_ff;
   logic              byp_hit_ff;
   logic [DATA_W-1:0] byp_data_ff;
   logic              rd_ok_ff;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   exc_type           rsp_exc_ff;
   logic              rsp_wvalid_ff;
   logic [ADDR_W-1:0] rsp_idx_ff;
   logic [DATA_W-1:0] rsp_data_ff;

   // per-entry written flags, clear means the entry reads zero
   logic [REG_COUNT-1:0] ent_valid_ff, ent_valid_in;

   logic              accept;
   logic              s1_adv;
   kind_type          req_kind;
   logic [ADDR_W-1:0] req_dest;
   logic [ADDR_W-1:0] raddr;
   logic              paired;
   logic [DATA_W-1:0] ram_rdata;
   logic [DATA_W-1:0] cop_value;
   commit_type        commit;
   wq_req_type        wq_req;

   exc_type           ex_exc;
   logic              ex_wvalid;
   logic [ADDR_W-1:0] ex_idx;
   logic [DATA_W-1:0] ex_data;
   logic [DATA_W-1:0] half_sel;

   assign paired = (COPROCESSOR_NUMBER != 0) && mode_64_ff;

   // ---------------- handshake ----------------
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign req_kind = kind_type'(req_tuser);
   assign req_dest = req_tdata[4:0];

   // MF and MT on a paired file read the even register of the pair
   always_comb begin
      raddr = req_dest;
      if (paired && ((req_kind == KIND_MF) || (req_kind == KIND_MT))) begin
         raddr = {req_dest[ADDR_W-1:1], 1'b0};
      end
   end

   // ---------------- register file ----------------
   cprm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (REG_COUNT)
   ) u_file (
      .clock (clock),
      .we    (commit.we),
      .waddr (commit.addr),
      .wdata (commit.data),
      .re    (accept),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   cprm_wq u_wq (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_adv),
      .tick    (s1_kind_ff == KIND_TICK),
      .req     (wq_req),
      .commit  (commit)
   );

   // forwarded commit wins, then a never-written entry reads zero
   always_comb begin
      if (byp_hit_ff) begin
         cop_value = byp_data_ff;
      end else if (rd_ok_ff) begin
         cop_value = ram_rdata;
      end else begin
         cop_value = '0;
      end
   end

   always_comb begin
      ent_valid_in = ent_valid_ff;
      if (commit.we) begin
         ent_valid_in[commit.addr] = 1'b1;
      end
   end

   // ---------------- execute ----------------
   always_comb begin
      ex_exc    = EXC_NONE;
      ex_wvalid = 1'b0;
      ex_idx    = '0;
      ex_data   = '0;
      wq_req    = '0;
      half_sel  = '0;
      case (s1_kind_ff)
         KIND_MF: begin
            if (!usable_ff) begin
               ex_exc = EXC_UNUSABLE;
            end else begin
               if (paired) begin
                  half_sel = s1_dest_ff[0] ? {{HALF_W{1'b0}}, cop_value[DATA_W-1:HALF_W]}
                                           : {{HALF_W{1'b0}}, cop_value[HALF_W-1:0]};
               end else begin
                  half_sel = cop_value;
               end
               // sign-extend bit 31 in 64-bit mode
               if (mode_64_ff) begin
                  ex_data = {{HALF_W{half_sel[HALF_W-1]}}, half_sel[HALF_W-1:0]};
               end else begin
                  ex_data = half_sel;
               end
               ex_wvalid = 1'b1;
               ex_idx    = s1_target_ff;
            end
         end
         KIND_DMF: begin
            if (!usable_ff) begin
               ex_exc = EXC_UNUSABLE;
            end else if (reserved_64_ff) begin
               ex_exc = EXC_RESERVED;
            end else begin
               ex_data   = cop_value;
               ex_wvalid = 1'b1;
               ex_idx    = s1_target_ff;
            end
         end
         KIND_MT: begin
            if (!usable_ff) begin
               ex_exc = EXC_UNUSABLE;
            end else begin
               wq_req.valid = 1'b1;
               if (paired) begin
                  // replace one half of the even register, keep the committed other half
                  wq_req.addr = {s1_dest_ff[ADDR_W-1:1], 1'b0};
                  if (s1_dest_ff[0]) begin
                     wq_req.data = {s1_gpr_ff[HALF_W-1:0], cop_value[HALF_W-1:0]};
                  end else begin
                     wq_req.data = {cop_value[DATA_W-1:HALF_W], s1_gpr_ff[HALF_W-1:0]};
                  end
               end else begin
                  wq_req.addr = s1_dest_ff;
                  wq_req.data = s1_gpr_ff;
               end
            end
         end
         KIND_DMT: begin
            if (!usable_ff) begin
               ex_exc = EXC_UNUSABLE;
            end else if (reserved_64_ff) begin
               ex_exc = EXC_RESERVED;
            end else begin
               wq_req.valid = 1'b1;
               wq_req.addr  = s1_dest_ff;
               wq_req.data  = s1_gpr_ff;
            end
         end
         KIND_UNUSABLE: begin
            ex_exc = EXC_UNUSABLE;
         end
         KIND_RESERVED: begin
            ex_exc = EXC_RESERVED;
         end
         default: begin
            // tick and no-op report nothing
         end
      endcase
   end

   // ---------------- stage control ----------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_ff      <= 1'b0;
         mode_64_ff     <= 1'b0;
         reserved_64_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         ent_valid_ff   <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_USABLE:     usable_ff      <= csr_data;
               CSR_MODE_64:    mode_64_ff     <= csr_data;
               CSR_RESERVED64: reserved_64_ff <= csr_data;
               default: begin
                  // unknown index: drop the write
               end
            endcase
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ent_valid_ff <= ent_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff   <= req_kind;
         s1_dest_ff   <= req_dest;
         s1_target_ff <= req_tdata[9:5];
         s1_gpr_ff    <= req_tdata[73:10];
         // catch a commit to the entry being read in this same cycle
         byp_hit_ff   <= commit.we && (commit.addr == raddr);
         byp_data_ff  <= commit.data;
         rd_ok_ff     <= ent_valid_ff[raddr];
      end
      if (s1_adv) begin
         rsp_exc_ff    <= ex_exc;
         rsp_wvalid_ff <= ex_wvalid;
         rsp_idx_ff    <= ex_idx;
         rsp_data_ff   <= ex_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_wvalid_ff, rsp_exc_ff};
   assign rsp_tdata  = {3'b000, rsp_data_ff, rsp_idx_ff};

   // ---------------- assertions ----------------
   a_commit_on_tick: assert property (@(posedge clock) disable iff (reset)
      commit.we |-> (s1_adv && (s1_kind_ff == KIND_TICK)))
      else $error("register file written outside an advancing tick");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item did not enter the execute stage");

   a_adv_result: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("advancing item produced no result");

   a_exc_no_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_exc_ff != EXC_NONE)) |-> !rsp_wvalid_ff)
      else $error("load requested together with an exception");

   a_stall_holds_s1: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_kind_ff)))
      else $error("stalled execute stage lost its item");

endmodule

>>> dv/coprocessor_register_move_unit_tb.sv
// Self-checking testbench for the coprocessor register move unit: directed and random moves.
module coprocessor_register_move_unit_tb;
   import cprm_pkg::*;

   localparam int unsigned COP_NUM      = 1;
   localparam int unsigned IDLE_PCT     = 21;   // chance in a hundred that a side idles
   localparam int unsigned HOLD_CYCLES  = 80;   // long receiver hold-off
   localparam int unsigned QUIET_LIMIT  = 2000; // cycles without any handshake
   localparam int unsigned DRAIN_CYCLES = 4;    // margin for the last results to drain

   // One result item as the unit reports it.
   typedef struct packed {
      exc_type           exc;
      logic              load;
      logic [ADDR_W-1:0] gpr;
      logic [DATA_W-1:0] value;
   } move_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;  // dest_reg[4:0], target_reg[9:5], gpr_value[73:10]
   logic [2:0]  req_tuser  = KIND_NOP;  // kind[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // gpr_index[4:0], gpr_data[68:5]
   logic [2:0]  rsp_tuser;        // exception[1:0], gpr_write_valid[2]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = CSR_USABLE;
   logic        csr_data   = 1'b0;

   // Shadow of the unit: committed file, the two write slots and the status bits.
   logic [DATA_W-1:0] cop_file [REG_COUNT];
   logic              staged_valid = 1'b0;
   logic [ADDR_W-1:0] staged_idx   = '0;
   logic [DATA_W-1:0] staged_val   = '0;
   logic              aged_valid   = 1'b0;
   logic [ADDR_W-1:0] aged_idx     = '0;
   logic [DATA_W-1:0] aged_val     = '0;
   logic              cfg_usable   = 1'b0;
   logic              cfg_wide     = 1'b0;
   logic              cfg_dw_rsvd  = 1'b0;

   move_result_type due_results [$];
   move_result_type oldest_due;
   int unsigned  mismatches = 0;
   logic         steady     = 1'b0;  // suppress idling on both sides
   logic         hold_rsp   = 1'b0;  // ask the receiver for a long hold-off

   coprocessor_register_move_unit #(
      .COPROCESSOR_NUMBER(COP_NUM)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   initial begin
      for (int i = 0; i < REG_COUNT; i++) cop_file[i] = '0;
   end

   // Queue a coprocessor write in the staged slot; a write to the index of the
   // aged slot drops that aged write.
   function automatic void stage_write(logic [ADDR_W-1:0] idx, logic [DATA_W-1:0] val);
      staged_valid = 1'b1;
      staged_idx   = idx;
      staged_val   = val;
      if (aged_valid && aged_idx == idx) begin
         aged_valid = 1'b0;
         aged_idx   = '0;
         aged_val   = '0;
      end
   endfunction

   // Execute one instruction item on the shadow state and return its result.
   function automatic move_result_type execute_move(kind_type kind, logic [ADDR_W-1:0] rd,
                                                 logic [ADDR_W-1:0] rt, logic [DATA_W-1:0] gv);
      move_result_type   res;
      logic              paired;
      logic [ADDR_W-1:0] even_rd;
      logic [DATA_W-1:0] word;
      res     = '0;
      paired  = (COP_NUM != 0) && cfg_wide;
      even_rd = {rd[ADDR_W-1:1], 1'b0};
      case (kind)
         KIND_TICK: begin
            // Commit the aged slot, then age the staged slot.
            if (aged_valid) cop_file[aged_idx] = aged_val;
            aged_valid   = staged_valid;
            aged_idx     = staged_idx;
            aged_val     = staged_val;
            staged_valid = 1'b0;
            staged_idx   = '0;
            staged_val   = '0;
         end
         KIND_MF: begin
            if (!cfg_usable) begin
               res.exc = EXC_UNUSABLE;
            end else begin
               if (paired)
                  word = rd[0] ? {32'd0, cop_file[even_rd][63:32]}
                               : {32'd0, cop_file[even_rd][31:0]};
               else
                  word = cop_file[rd];
               if (cfg_wide) word = {{HALF_W{word[31]}}, word[31:0]};
               res.load  = 1'b1;
               res.gpr   = rt;
               res.value = word;
            end
         end
         KIND_DMF: begin
            if (!cfg_usable) begin
               res.exc = EXC_UNUSABLE;
            end else if (cfg_dw_rsvd) begin
               res.exc = EXC_RESERVED;
            end else begin
               res.load  = 1'b1;
               res.gpr   = rt;
               res.value = cop_file[rd];
            end
         end
         KIND_MT: begin
            if (!cfg_usable) begin
               res.exc = EXC_UNUSABLE;
            end else if (paired) begin
               // Merge into the committed even register; staged writes are not seen.
               word = cop_file[even_rd];
               if (rd[0]) word[63:32] = gv[31:0];
               else word[31:0] = gv[31:0];
               stage_write(even_rd, word);
            end else begin
               stage_write(rd, gv);
            end
         end
         KIND_DMT: begin
            if (!cfg_usable) res.exc = EXC_UNUSABLE;
            else if (cfg_dw_rsvd) res.exc = EXC_RESERVED;
            else stage_write(rd, gv);
         end
         KIND_UNUSABLE: res.exc = EXC_UNUSABLE;
         KIND_RESERVED: res.exc = EXC_RESERVED;
         default: ;
      endcase
      return res;
   endfunction

   task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Monitor: predict on each accepted item, track status writes, and check
   // each accepted result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            due_results.push_back(execute_move(kind_type'(req_tuser), req_tdata[4:0],
                                               req_tdata[9:5], req_tdata[73:10]));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_USABLE:     cfg_usable  = csr_data;
               CSR_MODE_64:    cfg_wide    = csr_data;
               CSR_RESERVED64: cfg_dw_rsvd = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %0h/%0h",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               oldest_due = due_results.pop_front();
               check_field("exception", oldest_due.exc, rsp_tuser[1:0]);
               check_field("gpr_write_valid", oldest_due.load, rsp_tuser[2]);
               check_field("gpr_index", oldest_due.gpr, rsp_tdata[4:0]);
               check_field("gpr_data", oldest_due.value, rsp_tdata[68:5]);
            end
         end
      end
   end

   // Receiver: stall at random, or hold off for a long stretch on request.
   always begin
      @(posedge clock);
      if (hold_rsp) begin
         rsp_tready <= 1'b0;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_rsp = 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog: end the run once no channel has moved for too long.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Offer one instruction item, idling first at random, and hold it until accepted.
   task automatic send_move(kind_type kind, logic [ADDR_W-1:0] rd, logic [ADDR_W-1:0] rt,
                            logic [DATA_W-1:0] gv);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, gv, rt, rd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
   endtask

   task automatic write_csr(logic [1:0] idx, logic val);
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Write all three status bits once the unit is idle.
   task automatic apply_settings(logic usable, logic wide, logic dw_rsvd);
      wait_for_results();
      csr_valid <= 1'b1;
      write_csr(CSR_USABLE, usable);
      write_csr(CSR_MODE_64, wide);
      write_csr(CSR_RESERVED64, dw_rsvd);
      csr_valid <= 1'b0;
   endtask

   // Out of reset the coprocessor is unusable: every move faults, and the no-op reports nothing.
   task automatic test_disabled_unit();
      send_move(KIND_MF, 5'd31, 5'd31, '0);
      send_move(KIND_DMF, 5'd0, 5'd0, '0);
      send_move(KIND_MT, 5'd31, 5'd0, '1);
      send_move(KIND_DMT, 5'd0, 5'd31, '1);
      send_move(KIND_UNUSABLE, 5'd0, 5'd0, '0);
      send_move(KIND_RESERVED, 5'd31, 5'd31, '1);
      send_move(KIND_NOP, 5'd31, 5'd31, '1);
   endtask

   // A write lands only after two ticks; reads see committed registers only;
   // a write to the aged index cancels it, a second write replaces the staged one.
   task automatic test_commit_path();
      apply_settings(1'b1, 1'b0, 1'b0);
      send_move(KIND_DMT, 5'd31, 5'd0, '1);
      send_move(KIND_DMF, 5'd31, 5'd31, '0);
      send_move(KIND_TICK, 5'd0, 5'd0, '0);
      send_move(KIND_TICK, 5'd0, 5'd0, '0);
      send_move(KIND_MF, 5'd31, 5'd0, '0);
      send_move(KIND_MT, 5'd7, 5'd0, 64'h0123_4567_89ab_cdef);
      send_move(KIND_TICK, 5'd0, 5'd0, '0);
      send_move(KIND_DMT, 5'd7, 5'd0, 64'hfedc_ba98_7654_3210);
      send_move(KIND_DMT, 5'd9, 5'd0, 64'h8000_0000_0000_0001);
      send_move(KIND_TICK, 5'd0, 5'd0, '0);
      send_move(KIND_TICK, 5'd0, 5'd0, '0);
      send_move(KIND_DMF, 5'd7, 5'd3, '0);
      send_move(KIND_DMF, 5'd9, 5'd4, '0);
   endtask

   // 64-bit mode: odd index moves the high half of the even register, MF
   // sign-extends; then doubleword moves become reserved.
   task automatic test_paired_halves();
      apply_settings(1'b1, 1'b1, 1'b0);
      send_move(KIND_MT, 5'd31, 5'd0, 64'hffff_ffff_8000_0000);
      send_move(KIND_TICK, 5'd0, 5'd0, '0);
      send_move(KIND_TICK, 5'd0, 5'd0, '0);
      send_move(KIND_MF, 5'd30, 5'd1, '0);
      send_move(KIND_MF, 5'd31, 5'd2, '0);
      apply_settings(1'b1, 1'b1, 1'b1);
      send_move(KIND_DMF, 5'd30, 5'd5, '0);
      send_move(KIND_DMT, 5'd0, 5'd6, '1);
   endtask

   // Hold the receiver off while the sender keeps offering, so the unit fills
   // and stalls its input; then pause the sender until all results are back.
   task automatic test_backpressure();
      apply_settings(1'b1, 1'b0, 1'b0);
      steady   = 1'b1;
      hold_rsp = 1'b1;
      for (int i = 0; i < 30; i++)
         send_move((i % 3 == 0) ? KIND_DMT : (i % 3 == 1) ? KIND_DMF : KIND_TICK,
                   i[4:0], 5'(31 - i), {$urandom, $urandom});
      steady = 1'b0;
      wait_for_results();
      for (int i = 0; i < 12; i++)
         send_move((i % 2 == 0) ? KIND_TICK : KIND_MF, 5'(i * 3), i[4:0], '0);
   endtask

   // Random moves under one setting; most indexes fall on one register pair
   // so that cancels, overwrites and half merges happen often.
   task automatic run_random_phase(logic usable, logic wide, logic dw_rsvd, int unsigned count);
      kind_type          kind;
      int unsigned       pick;
      logic [3:0]        hot_pair;
      logic [ADDR_W-1:0] rd;
      logic [DATA_W-1:0] gv;
      apply_settings(usable, wide, dw_rsvd);
      hot_pair = 4'($urandom_range(15));
      repeat (count) begin
         if ($urandom_range(15) == 0) hot_pair = 4'($urandom_range(15));
         pick = $urandom_range(99);
         kind = (pick < 25) ? KIND_TICK :
                (pick < 45) ? KIND_MF :
                (pick < 60) ? KIND_DMF :
                (pick < 75) ? KIND_MT :
                (pick < 90) ? KIND_DMT :
                (pick < 94) ? KIND_UNUSABLE :
                (pick < 97) ? KIND_RESERVED : KIND_NOP;
         rd = 5'($urandom_range(31));
         if ($urandom_range(99) < 60) rd[4:1] = hot_pair;
         case ($urandom_range(7))
            0: gv = '1;
            1: gv = '0;
            2: gv = {$urandom, 1'b1, 31'($urandom)};
            default: gv = {$urandom, $urandom};
         endcase
         send_move(kind, rd, 5'($urandom_range(31)), gv);
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(1'b1, 1'b0, 1'b0, 160);
      steady = 1'b1;
      run_random_phase(1'b1, 1'b1, 1'b0, 160);
      steady = 1'b0;
      run_random_phase(1'b1, 1'b0, 1'b1, 160);
      run_random_phase(1'b1, 1'b1, 1'b1, 160);
      run_random_phase(1'b0, 1'b1, 1'b1, 50);
      run_random_phase(1'b1, 1'b0, 1'b0, 160);
      run_random_phase(1'b1, 1'b1, 1'b0, 160);
   endtask

   // Sequence the tests, drain, and report.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_disabled_unit();
      test_commit_path();
      test_paired_halves();
      test_backpressure();
      test_random_traffic();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && due_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
